### design/pbim_pkg.sv
package pbim_pkg;

    // Q1.16 probability format; PROB_ONE stands for one
    localparam int unsigned PROB_FRAC = 16;
    localparam int unsigned PROB_W    = 17;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_W     = 6;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [4:0]        row_index;
        logic [WORD_W-1:0] row_mask;
        logic [PROB_W-1:0] row_prob;
        logic [WORD_W-1:0] state_in;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] new_state;
        logic [PROB_W-1:0] probability;
    } t_rsp;

endpackage

### design/parity_basis_independent_model_eval.sv
// Parity-basis independent model evaluator.
//
// Input channel (i_valid / o_ready, payload i_req) carries two kinds of request.
// A load request (opcode OP_LOAD) writes one basis row: mask and p1. It gives no
// response and does not make the block busy, so loads can follow back to back. An
// out-of-range row index is dropped; p1 above one is clipped to one. An evaluate
// request (opcode OP_EVAL) transforms a state into the operator basis and returns
// one response on the output channel (o_valid / i_ready, payload o_rsp): new_state
// and the Q1.16 probability. The first table read is issued in the accepting
// cycle, each following cycle folds in one row (one table read and one multiply
// into the running product), and the finish state then hands the result over to
// the output register. o_ready stays low until the evaluator is idle again. A
// stalled receiver holds its response in the output register; the next evaluate
// request still runs, then waits at the handover with o_ready low. active_rows
// is written through i_cfg_we / i_cfg_wdata; the user must do so only while the
// block is idle, which the block itself does not enforce. Reset clears the
// evaluator state, the output valid and active_rows; the basis table is not
// cleared and rows must be loaded before they are evaluated.
module parity_basis_independent_model_eval #(
    parameter int unsigned N_BITS   = 32,
    parameter int unsigned MAX_ROWS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pbim_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pbim_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic [pbim_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int unsigned IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CW = $clog2(MAX_ROWS + 1);
    localparam logic [pbim_pkg::WORD_W-1:0] BITS_MASK =
        pbim_pkg::WORD_W'((64'd1 << N_BITS) - 64'd1);
    localparam logic [5:0] MAX_ROWS_IDX = 6'(MAX_ROWS);

    logic [pbim_pkg::CFG_W-1:0]  r_active;
    logic                        w_accept;
    logic                        w_we;
    logic                        w_start;
    logic                        w_busy;
    logic [pbim_pkg::PROB_W-1:0] w_wprob;
    logic                        w_rd_en;
    logic [IW-1:0]               w_rd_addr;
    logic [pbim_pkg::WORD_W-1:0] w_rd_mask;
    logic [pbim_pkg::PROB_W-1:0] w_rd_prob;

    // active row count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign o_ready  = !w_busy;
    assign w_accept = i_valid && o_ready;

    // load: drop rows past the table, clip p1 at one
    assign w_we    = w_accept && (i_req.opcode == pbim_pkg::OP_LOAD)
                     && ({1'b0, i_req.row_index} < MAX_ROWS_IDX);
    assign w_wprob = (i_req.row_prob > pbim_pkg::PROB_ONE) ? pbim_pkg::PROB_ONE
                                                            : i_req.row_prob;
    assign w_start = w_accept && (i_req.opcode == pbim_pkg::OP_EVAL);

    pbim_table #(
        .MAX_ROWS (MAX_ROWS),
        .IW       (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_req.row_index[IW-1:0]),
        .i_wmask (i_req.row_mask & BITS_MASK),
        .i_wprob (w_wprob),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rmask (w_rd_mask),
        .o_rprob (w_rd_prob)
    );

    pbim_eval #(
        .MAX_ROWS (MAX_ROWS),
        .IW       (IW),
        .CW       (CW)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_state   (i_req.state_in & BITS_MASK),
        .i_active  (r_active),
        .o_busy    (w_busy),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_mask (w_rd_mask),
        .i_rd_prob (w_rd_prob),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp     (o_rsp)
    );

    // the running product never grows past one
    a_prob_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.probability <= pbim_pkg::PROB_ONE))
        else $error("probability above one");

    // a table write never shares a cycle with an evaluation read
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_rd_en))
        else $error("table write during evaluation read");

    // an accepted evaluate request holds off the next request
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_req.opcode == pbim_pkg::OP_EVAL)) |=> !o_ready)
        else $error("request accepted while evaluating");

endmodule

### design/pbim_table.sv
module pbim_table #(
    parameter int unsigned MAX_ROWS = 32,
    parameter int unsigned IW       = 5
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [IW-1:0]                 i_waddr,
    input  logic [pbim_pkg::WORD_W-1:0]   i_wmask,
    input  logic [pbim_pkg::PROB_W-1:0]   i_wprob,
    input  logic                          i_re,
    input  logic [IW-1:0]                 i_raddr,
    output logic [pbim_pkg::WORD_W-1:0]   o_rmask,
    output logic [pbim_pkg::PROB_W-1:0]   o_rprob
);

    logic [pbim_pkg::WORD_W-1:0] r_mask_mem [MAX_ROWS];
    logic [pbim_pkg::PROB_W-1:0] r_prob_mem [MAX_ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mask_mem[i_waddr] <= i_wmask;
            r_prob_mem[i_waddr] <= i_wprob;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rmask <= r_mask_mem[i_raddr];
            o_rprob <= r_prob_mem[i_raddr];
        end
    end

endmodule

### design/pbim_eval.sv
module pbim_eval #(
    parameter int unsigned MAX_ROWS = 32,
    parameter int unsigned IW       = 5,
    parameter int unsigned CW       = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pbim_pkg::WORD_W-1:0]   i_state,
    input  logic [pbim_pkg::CFG_W-1:0]    i_active,
    output logic                          o_busy,
    output logic                          o_rd_en,
    output logic [IW-1:0]                 o_rd_addr,
    input  logic [pbim_pkg::WORD_W-1:0]   i_rd_mask,
    input  logic [pbim_pkg::PROB_W-1:0]   i_rd_prob,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pbim_pkg::t_rsp                o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    localparam logic [pbim_pkg::CFG_W-1:0] MAX_ROWS_CFG = pbim_pkg::CFG_W'(MAX_ROWS);

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_rows, n_rows;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [IW-1:0]                 r_cons, n_cons;
    logic [pbim_pkg::WORD_W-1:0]   r_st, n_st;
    logic [pbim_pkg::WORD_W-1:0]   r_ns, n_ns;
    logic [pbim_pkg::PROB_W-1:0]   r_prob, n_prob;
    logic                          r_out_valid, n_out_valid;
    pbim_pkg::t_rsp                r_rsp, n_rsp;

    logic [CW-1:0]                 w_rows;
    logic                          w_odd;
    logic [pbim_pkg::PROB_W-1:0]   w_factor;
    logic [2*pbim_pkg::PROB_W-1:0] w_prod;
    logic                          w_out_free;

    assign w_rows = (i_active > MAX_ROWS_CFG) ? CW'(MAX_ROWS) : CW'(i_active);

    assign w_odd    = ^(i_rd_mask & r_st);
    assign w_factor = w_odd ? i_rd_prob : (pbim_pkg::PROB_ONE - i_rd_prob);
    assign w_prod   = r_prob * w_factor;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                o_rd_en = i_start && (w_rows != '0);
            end
            S_RUN: begin
                o_rd_en   = r_cnt < r_rows;
                o_rd_addr = r_cnt[IW-1:0];
            end
            S_FIN: begin
                o_rd_en = 1'b0;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_cnt       = r_cnt;
        n_cons      = r_cons;
        n_st        = r_st;
        n_ns        = r_ns;
        n_prob      = r_prob;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rows  = w_rows;
                    n_cnt   = CW'(1);
                    n_cons  = '0;
                    n_st    = i_state;
                    n_ns    = '0;
                    n_prob  = pbim_pkg::PROB_ONE;
                    n_state = (w_rows == '0) ? S_FIN : S_RUN;
                end
            end
            S_RUN: begin
                // fold in the row read last cycle, issue the next read
                n_prob = w_prod[pbim_pkg::PROB_FRAC +: pbim_pkg::PROB_W];
                n_ns   = r_ns | (pbim_pkg::WORD_W'(w_odd) << r_cons);
                n_cnt  = r_cnt + CW'(1);
                n_cons = r_cons + IW'(1);
                if (CW'(r_cons) == r_rows - CW'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_rsp.new_state   = r_ns;
                    n_rsp.probability = r_prob;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows <= n_rows;
        r_cnt  <= n_cnt;
        r_cons <= n_cons;
        r_st   <= n_st;
        r_ns   <= n_ns;
        r_prob <= n_prob;
        r_rsp  <= n_rsp;
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule
